// File: hdl/ttd_pkg.sv
package ttd_pkg;

    localparam int SEGMENTS_DEF     = 10;
    localparam int CAPTURE_BITS_DEF = 16;

    localparam int CAP_FIELD_W  = 16;
    localparam int POT_W        = 10;
    localparam int OPCODE_W     = 2;
    localparam int CODE_W       = 12;
    localparam int ELAPSED_W    = 10;
    localparam int TIMEOUT_W    = 10;
    localparam int TICKS_W      = 8;
    localparam int DEADBAND_W   = 6;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 10;
    localparam int IN_DATA_W    = 32;
    localparam int OUT_DATA_W   = 16;
    localparam int OUT_USER_W   = 2;

    localparam int SEG_IDX_W    = 4;
    localparam int SEG_IDX_MAX  = 15;
    localparam int DELAY_W      = 10;
    localparam int ICPT_W       = 22;
    localparam int GAIN_W       = 24;
    localparam int FRAC_BITS    = 12;
    localparam int RECIP_SHIFT  = 2 * FRAC_BITS;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int DIFF_W       = RECIP_W + 2;
    localparam int PROD_W       = RECIP_W + GAIN_W;

    localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX   = 10'd1000;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST   = 10'd900;
    localparam logic [TICKS_W-1:0]    TICKS_RST     = 8'd62;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST  = 6'd6;
    localparam logic [CODE_W-1:0]     CODE_MAX      = 12'd4095;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK = 2'd0,
        OP_TAP  = 2'd1,
        OP_POT  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIMEOUT  = 2'd0,
        REG_TICKS    = 2'd1,
        REG_DEADBAND = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_W,
        ST_DIV_F,
        ST_MUL,
        ST_EMIT
    } t_state;

    function automatic logic [DELAY_W-1:0] seg_delay(input logic [SEG_IDX_W-1:0] idx);
        case (idx)
            4'd0:    seg_delay = 10'd879;
            4'd1:    seg_delay = 10'd821;
            4'd2:    seg_delay = 10'd745;
            4'd3:    seg_delay = 10'd665;
            4'd4:    seg_delay = 10'd572;
            4'd5:    seg_delay = 10'd470;
            4'd6:    seg_delay = 10'd356;
            4'd7:    seg_delay = 10'd220;
            4'd8:    seg_delay = 10'd93;
            default: seg_delay = 10'd66;
        endcase
    endfunction

    function automatic logic signed [ICPT_W-1:0] seg_icpt(input logic [SEG_IDX_W-1:0] idx);
        case (idx)
            4'd0:    seg_icpt = 22'sd18555;
            4'd1:    seg_icpt = 22'sd17613;
            4'd2:    seg_icpt = 22'sd16302;
            4'd3:    seg_icpt = 22'sd13967;
            4'd4:    seg_icpt = 22'sd8847;
            4'd5:    seg_icpt = -22'sd2417;
            4'd6:    seg_icpt = -22'sd34529;
            4'd7:    seg_icpt = -22'sd143811;
            4'd8:    seg_icpt = -22'sd794829;
            default: seg_icpt = -22'sd1243136;
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] seg_gain(input logic [SEG_IDX_W-1:0] idx);
        case (idx)
            4'd0:    seg_gain = 24'd13695722;
            4'd1:    seg_gain = 24'd4877110;
            4'd2:    seg_gain = 24'd3355452;
            4'd3:    seg_gain = 24'd2440329;
            4'd4:    seg_gain = 24'd1677726;
            4'd5:    seg_gain = 24'd1082404;
            4'd6:    seg_gain = 24'd587233;
            4'd7:    seg_gain = 24'd251194;
            4'd8:    seg_gain = 24'd63435;
            default: seg_gain = 24'd43455;
        endcase
    endfunction

endpackage

// File: hdl/ttd_serial_div.sv
module ttd_serial_div #(
    parameter int DW = 25,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [DW-1:0]    r_q;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [VW:0]      trial;
    logic             ge;

    // restoring divide, one quotient bit per cycle, msb first
    assign trial = {r_rem, r_q[DW-1]};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_q   <= {r_q[DW-2:0], ge};
                r_rem <= ge ? VW'(trial - {1'b0, r_dvs}) : trial[VW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: hdl/ttd_serial_mul.sv
module ttd_serial_mul #(
    parameter int AW = 25,
    parameter int BW = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_product
);

    localparam int PW    = AW + BW;
    localparam int CNT_W = $clog2(AW + 1);

    logic [AW-1:0]    r_a;
    logic [PW-1:0]    r_b;
    logic [PW-1:0]    r_acc;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    // shift-add, one multiplier bit per cycle, lsb first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= PW'(i_b);
                r_acc  <= '0;
                r_cnt  <= CNT_W'(AW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_a[0]) begin
                    r_acc <= r_acc + r_b;
                end
                r_a   <= r_a >> 1;
                r_b   <= r_b << 1;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// File: hdl/ttd_seg_search.sv
module ttd_seg_search #(
    parameter int CW   = 16,
    parameter int LAST = 9
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [CW-1:0]                  i_width,
    output logic [ttd_pkg::SEG_IDX_W-1:0]  o_idx
);

    localparam logic [ttd_pkg::SEG_IDX_W-1:0] LAST_IDX = ttd_pkg::SEG_IDX_W'(LAST);

    logic [ttd_pkg::SEG_IDX_W-1:0] r_idx;
    logic [CW-1:0]                 r_w;
    logic                          r_busy;
    logic                          advance;

    // one table entry per cycle
    assign advance = (r_idx < LAST_IDX)
                  && (32'(ttd_pkg::seg_delay(r_idx)) >= 32'(r_w));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= ttd_pkg::SEG_IDX_W'(1);
        end else begin
            if (i_start) begin
                r_idx  <= ttd_pkg::SEG_IDX_W'(1);
                r_w    <= i_width;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (advance) begin
                    r_idx <= r_idx + 1'b1;
                end else begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_idx = r_idx;

endmodule

// File: hdl/tap_tempo_to_dac_code.sv
// channel  | dir | handshake                 | payload
// s (in)   | in  | i_s_tvalid / o_s_tready   | tdata: timer_capture, pot_sample; tuser: opcode
// m (out)  | out | o_m_tvalid / i_m_tready   | tdata: dac_code; tuser: from_tap, clamped
// cfg      | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// tick, pot sample and first tap are handled in idle; a pot code goes via the emit state
// a timed tap runs the serial divider twice (interval, then reciprocal) and then
// the serial multiplier
// the segment search runs beside the reciprocal divide and finishes before it
// reset is synchronous, active low; no memory clearing pass
// a word waiting at the output blocks input only while a new code waits for it
module tap_tempo_to_dac_code #(
    parameter int SEGMENTS     = ttd_pkg::SEGMENTS_DEF,
    parameter int CAPTURE_BITS = ttd_pkg::CAPTURE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ttd_pkg::IN_DATA_W-1:0]      i_s_tdata,   // timer_capture, pot_sample
    input  logic [ttd_pkg::OPCODE_W-1:0]       i_s_tuser,   // opcode
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ttd_pkg::OUT_DATA_W-1:0]     o_m_tdata,   // dac_code
    output logic [ttd_pkg::OUT_USER_W-1:0]     o_m_tuser,   // from_tap, clamped
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ttd_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [ttd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW       = CAPTURE_BITS;
    localparam int DW       = (CW > ttd_pkg::RECIP_W) ? CW : ttd_pkg::RECIP_W;
    localparam int SEG_LAST = (SEGMENTS - 1 > ttd_pkg::SEG_IDX_MAX) ? ttd_pkg::SEG_IDX_MAX :
                              ((SEGMENTS - 1 < 1) ? 1 : SEGMENTS - 1);
    localparam logic [DW-1:0] RECIP_NUM = DW'(1) << ttd_pkg::RECIP_SHIFT;

    ttd_pkg::t_state r_state, n_state;

    logic [ttd_pkg::TIMEOUT_W-1:0]  r_timeout;
    logic [ttd_pkg::TICKS_W-1:0]    r_tpm;
    logic [ttd_pkg::DEADBAND_W-1:0] r_deadband;
    logic [ttd_pkg::ELAPSED_W-1:0]  r_elapsed;
    logic                           r_awaiting;
    logic [CW-1:0]                  r_last;
    logic [ttd_pkg::POT_W-1:0]      r_saved_pot;

    logic [ttd_pkg::CODE_W-1:0]     r_res_code;
    logic                           r_res_tap;
    logic                           r_res_clamped;

    logic                           r_out_valid;
    logic [ttd_pkg::CODE_W-1:0]     r_out_code;
    logic                           r_out_tap;
    logic                           r_out_clamped;

    ttd_pkg::t_opcode               opcode;
    logic [31:0]                    cap32;
    logic [CW-1:0]                  cap;
    logic [CW-1:0]                  delta;
    logic [ttd_pkg::POT_W-1:0]      pot;
    logic                           in_acc;
    logic                           cfg_we;
    logic                           out_free;
    logic                           tap_restart;
    logic                           pot_move;
    logic signed [11:0]             pot_s, pot_hi, pot_lo;

    logic                           div_start;
    logic [DW-1:0]                  div_dividend;
    logic [CW-1:0]                  div_divisor;
    logic                           div_done;
    logic [DW-1:0]                  div_q;
    logic [CW-1:0]                  width;

    logic                           srch_start;
    logic [ttd_pkg::SEG_IDX_W-1:0]  seg_idx;

    logic                           mul_start;
    logic                           mul_done;
    logic [ttd_pkg::PROD_W-1:0]     prod;
    logic [ttd_pkg::RECIP_W-1:0]    prod_hi;

    logic signed [ttd_pkg::DIFF_W-1:0] diff;
    logic                              diff_neg;

    assign opcode   = ttd_pkg::t_opcode'(i_s_tuser);
    assign cap32    = 32'(i_s_tdata[ttd_pkg::CAP_FIELD_W-1:0]);
    assign cap      = cap32[CW-1:0];
    assign delta    = cap - r_last;
    assign pot      = i_s_tdata[ttd_pkg::CAP_FIELD_W +: ttd_pkg::POT_W];
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign cfg_we   = i_cfg_valid && o_cfg_ready;
    assign out_free = !r_out_valid || i_m_tready;

    assign tap_restart = r_awaiting || (r_elapsed >= r_timeout);

    // signed deadband test
    assign pot_s    = $signed({2'b00, pot});
    assign pot_hi   = $signed({2'b00, r_saved_pot}) + $signed({6'b0, r_deadband});
    assign pot_lo   = $signed({2'b00, r_saved_pot}) - $signed({6'b0, r_deadband});
    assign pot_move = (pot_s > pot_hi) || (pot_s < pot_lo);

    assign width    = div_q[CW-1:0];
    assign diff     = $signed({2'b00, div_q[ttd_pkg::RECIP_W-1:0]})
                    - ttd_pkg::DIFF_W'(ttd_pkg::seg_icpt(seg_idx));
    assign diff_neg = diff[ttd_pkg::DIFF_W-1];
    assign prod_hi  = prod[ttd_pkg::PROD_W-1:ttd_pkg::RECIP_SHIFT];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ttd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (opcode)
                        ttd_pkg::OP_TAP: begin
                            if (!tap_restart) begin
                                n_state = (r_tpm == '0) ? ttd_pkg::ST_EMIT : ttd_pkg::ST_DIV_W;
                            end
                        end
                        ttd_pkg::OP_POT: begin
                            if (pot_move) begin
                                n_state = ttd_pkg::ST_EMIT;
                            end
                        end
                        default: n_state = ttd_pkg::ST_IDLE;
                    endcase
                end
            end
            ttd_pkg::ST_DIV_W: begin
                if (div_done) begin
                    n_state = (width == '0) ? ttd_pkg::ST_EMIT : ttd_pkg::ST_DIV_F;
                end
            end
            ttd_pkg::ST_DIV_F: begin
                if (div_done) begin
                    n_state = diff_neg ? ttd_pkg::ST_EMIT : ttd_pkg::ST_MUL;
                end
            end
            ttd_pkg::ST_MUL: begin
                if (mul_done) begin
                    n_state = ttd_pkg::ST_EMIT;
                end
            end
            ttd_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = ttd_pkg::ST_IDLE;
                end
            end
            default: n_state = ttd_pkg::ST_IDLE;
        endcase
    end

    // unit control
    always_comb begin
        o_s_tready   = 1'b0;
        div_start    = 1'b0;
        srch_start   = 1'b0;
        mul_start    = 1'b0;
        div_dividend = DW'(delta);
        div_divisor  = CW'(r_tpm);
        case (r_state)
            ttd_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                div_start  = i_s_tvalid && (opcode == ttd_pkg::OP_TAP)
                          && !tap_restart && (r_tpm != '0);
            end
            ttd_pkg::ST_DIV_W: begin
                div_dividend = RECIP_NUM;
                div_divisor  = width;
                div_start    = div_done && (width != '0);
                srch_start   = div_done && (width != '0);
            end
            ttd_pkg::ST_DIV_F: begin
                mul_start = div_done && !diff_neg;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttd_pkg::ST_IDLE;
            r_timeout   <= ttd_pkg::TIMEOUT_RST;
            r_tpm       <= ttd_pkg::TICKS_RST;
            r_deadband  <= ttd_pkg::DEADBAND_RST;
            r_elapsed   <= '0;
            r_awaiting  <= 1'b1;
            r_last      <= '0;
            r_saved_pot <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_we) begin
                case (ttd_pkg::t_reg_idx'(i_cfg_index))
                    ttd_pkg::REG_TIMEOUT:  r_timeout  <= i_cfg_data;
                    ttd_pkg::REG_TICKS:    r_tpm      <= i_cfg_data[ttd_pkg::TICKS_W-1:0];
                    ttd_pkg::REG_DEADBAND: r_deadband <= i_cfg_data[ttd_pkg::DEADBAND_W-1:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                case (opcode)
                    ttd_pkg::OP_TICK: begin
                        if (r_elapsed < ttd_pkg::ELAPSED_MAX) begin
                            r_elapsed <= r_elapsed + 1'b1;
                        end
                    end
                    ttd_pkg::OP_TAP: begin
                        r_elapsed  <= '0;
                        r_awaiting <= 1'b0;
                        r_last     <= cap;
                        if (!tap_restart && (r_tpm == '0)) begin
                            r_res_code    <= ttd_pkg::CODE_MAX;
                            r_res_tap     <= 1'b1;
                            r_res_clamped <= 1'b1;
                        end
                    end
                    ttd_pkg::OP_POT: begin
                        if (pot_move) begin
                            r_saved_pot   <= pot;
                            r_res_code    <= {pot, 2'b00};
                            r_res_tap     <= 1'b0;
                            r_res_clamped <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end

            // zero width
            if (r_state == ttd_pkg::ST_DIV_W && div_done && width == '0) begin
                r_res_code    <= ttd_pkg::CODE_MAX;
                r_res_tap     <= 1'b1;
                r_res_clamped <= 1'b1;
            end

            // below the curve
            if (r_state == ttd_pkg::ST_DIV_F && div_done && diff_neg) begin
                r_res_code    <= '0;
                r_res_tap     <= 1'b1;
                r_res_clamped <= 1'b1;
            end

            if (r_state == ttd_pkg::ST_MUL && mul_done) begin
                r_res_tap <= 1'b1;
                if (|prod_hi[ttd_pkg::RECIP_W-1:ttd_pkg::CODE_W]) begin
                    r_res_code    <= ttd_pkg::CODE_MAX;
                    r_res_clamped <= 1'b1;
                end else begin
                    r_res_code    <= prod_hi[ttd_pkg::CODE_W-1:0];
                    r_res_clamped <= 1'b0;
                end
            end

            if (r_state == ttd_pkg::ST_EMIT && out_free) begin
                r_out_valid   <= 1'b1;
                r_out_code    <= r_res_code;
                r_out_tap     <= r_res_tap;
                r_out_clamped <= r_res_clamped;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    ttd_serial_div #(
        .DW (DW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    ttd_seg_search #(
        .CW   (CW),
        .LAST (SEG_LAST)
    ) u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (srch_start),
        .i_width (width),
        .o_idx   (seg_idx)
    );

    ttd_serial_mul #(
        .AW (ttd_pkg::RECIP_W),
        .BW (ttd_pkg::GAIN_W)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (diff[ttd_pkg::RECIP_W-1:0]),
        .i_b       (ttd_pkg::seg_gain(seg_idx)),
        .o_done    (mul_done),
        .o_product (prod)
    );

    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = ttd_pkg::OUT_DATA_W'(r_out_code);
    assign o_m_tuser   = {r_out_clamped, r_out_tap};

endmodule
